### src/rpt_pkg.sv
// shared types, constants and helpers for the region permission table
package rpt_pkg;

  localparam int MaxRegions    = 16;
  localparam int MaxVmids      = 16;
  localparam int MetaLineBytes = 64;

  localparam logic [40:0] LimitBytes = 41'h100_0000_0000;
  localparam logic [27:0] MaxCount   = 28'hFFF_FFFF;

  typedef enum logic [2:0] {
    OP_CREATE  = 3'd0,
    OP_GRANT   = 3'd1,
    OP_REVOKE  = 3'd2,
    OP_DESTROY = 3'd3,
    OP_QUERY   = 3'd4,
    OP_CHECK   = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NOTFOUND  = 3'd1,
    ST_DENIED    = 3'd2,
    ST_INVALID   = 3'd3,
    ST_EXHAUSTED = 3'd4,
    ST_FULL      = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    CFG_VMID_COUNT = 2'd0,
    CFG_PAGE_LOG2  = 2'd1,
    CFG_META_BASE  = 2'd2,
    CFG_META_BYTES = 2'd3
  } cfg_index_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_EXEC,
    S_OUT
  } state_t;

  // lookup key travelling down the cell chain
  typedef struct packed {
    logic        by_page;
    logic [31:0] id;
    logic [35:0] page;
  } key_t;

  // match result travelling down the cell chain
  typedef struct packed {
    logic        hit;
    logic        any_free;
    logic [7:0]  idx;
    logic [7:0]  free_idx;
    logic [31:0] id;
    logic [35:0] base_page;
    logic [27:0] page_count;
    logic [3:0]  owner;
    logic [47:0] meta_base;
  } match_t;

  // metadata bytes per page for a given vm count
  function automatic logic [8:0] meta_per_page(input logic [8:0] vms);
    logic [8:0] m;
    m = vms + 9'(MetaLineBytes - 1);
    return 9'((m / 9'(MetaLineBytes)) * 9'(MetaLineBytes));
  endfunction

endpackage

### src/rpt_cell.sv
// one table entry: holds a region and compares it against the passing key
module rpt_cell #(
  parameter int Index = 0
) (
  input  logic            clk,
  input  logic            rst,
  input  rpt_pkg::key_t   key,
  input  rpt_pkg::match_t match_in,
  output rpt_pkg::match_t match_out,
  input  logic            wr_en,
  input  logic            clr_en,
  input  logic [31:0]     wr_id,
  input  logic [35:0]     wr_base_page,
  input  logic [27:0]     wr_page_count,
  input  logic [3:0]      wr_owner,
  input  logic [47:0]     wr_meta_base
);
  import rpt_pkg::*;

  logic        valid;
  logic [31:0] id;
  logic [35:0] base_page;
  logic [27:0] page_count;
  logic [3:0]  owner;
  logic [47:0] meta_base;
  logic        hit_here;
  logic [36:0] page_off;
  match_t      match_next;

  // entry storage
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (wr_en) begin
      valid <= 1'b1;
    end else if (clr_en) begin
      valid <= 1'b0;
    end
    if (wr_en) begin
      id         <= wr_id;
      base_page  <= wr_base_page;
      page_count <= wr_page_count;
      owner      <= wr_owner;
      meta_base  <= wr_meta_base;
    end
  end

  // compare by id or by page range
  always_comb begin
    page_off = {1'b0, key.page} - {1'b0, base_page};
    if (key.by_page) begin
      hit_here = valid && !page_off[36] && (page_off[35:0] < {8'd0, page_count});
    end else begin
      hit_here = valid && (id == key.id);
    end
  end

  // lower index wins: pass an earlier hit through
  always_comb begin
    match_next = match_in;
    if (!match_in.any_free && !valid) begin
      match_next.any_free = 1'b1;
      match_next.free_idx = 8'(Index);
    end
    if (!match_in.hit && hit_here) begin
      match_next.hit        = 1'b1;
      match_next.idx        = 8'(Index);
      match_next.id         = id;
      match_next.base_page  = base_page;
      match_next.page_count = page_count;
      match_next.owner      = owner;
      match_next.meta_base  = meta_base;
    end
  end

  always_ff @(posedge clk) begin
    match_out <= match_next;
  end

endmodule

### src/region_permission_table.sv
// top level of the region permission table
// one operation at a time: the next input is taken only after the result
// has been taken, so a result that waits holds off the next input
// the match result walks the entry chain one cell per cycle, then the
// execute state applies the operation and registers the result
// reset: synchronous rst clears all entries, ids restart at 1, epoch 0
module region_permission_table #(
  parameter int MAX_REGIONS = rpt_pkg::MaxRegions
) (
  input  logic         clk,
  input  logic         rst,
  // op[2:0], requester_vmid[6:3], region_id[38:7], target_vmid[46:39],
  // perm_bits[49:47], create_bytes[90:50], create_page_base[126:91],
  // all_rw[127], phys_addr[175:128]
  input  logic [175:0] s_axis_tdata,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // status[2:0], result_region_id[34:3], region_bytes[75:35],
  // region_page_base[111:76], region_owner[115:112], access_allowed[116],
  // metadata_addr[164:117], permission_epoch[196:165]
  output logic [199:0] m_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [47:0]  cfg_data
);
  import rpt_pkg::*;

  localparam int IdxW   = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int CntW   = $clog2(MAX_REGIONS + 2);
  localparam int PermN  = MAX_REGIONS * MaxVmids;

  // configuration
  logic [4:0]  vmid_count;
  logic [4:0]  page_size_log2;
  logic [47:0] meta_win_base;
  logic [40:0] meta_win_bytes;

  always_ff @(posedge clk) begin
    if (rst) begin
      vmid_count     <= 5'd16;
      page_size_log2 <= 5'd12;
      meta_win_base  <= '0;
      meta_win_bytes <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_VMID_COUNT: vmid_count     <= cfg_data[4:0];
        CFG_PAGE_LOG2:  page_size_log2 <= cfg_data[4:0];
        CFG_META_BASE:  meta_win_base  <= cfg_data;
        CFG_META_BYTES: meta_win_bytes <= cfg_data[40:0];
        default: ;
      endcase
    end
  end

  // effective settings
  logic [8:0] vms;
  logic [4:0] lg;
  logic [8:0] mpp;
  always_comb begin
    if (vmid_count == 5'd0) vms = 9'd1;
    else if ({4'd0, vmid_count} > 9'(MaxVmids)) vms = 9'(MaxVmids);
    else vms = {4'd0, vmid_count};
    if (page_size_log2 < 5'd12) lg = 5'd12;
    else if (page_size_log2 > 5'd30) lg = 5'd30;
    else lg = page_size_log2;
    mpp = meta_per_page(vms);
  end

  // captured request
  logic [2:0]  op;
  logic [3:0]  req;
  logic [31:0] rid;
  logic [7:0]  tgt;
  logic [2:0]  perm;
  logic [40:0] cbytes;
  logic [35:0] cbase;
  logic        gall;
  logic [47:0] paddr;

  state_t state, state_next;
  logic [CntW-1:0] cnt;
  logic [31:0] next_id;
  logic [40:0] meta_used;
  logic [31:0] epoch;
  logic [2:0]  perm_mem [PermN];

  // precompute values for create
  logic [41:0] cnt_sum;
  logic [40:0] ccount;
  logic [41:0] win_sum;
  logic [40:0] win_r;
  logic [40:0] win_lim;
  logic [50:0] used_need;
  logic        c_invalid;
  logic [41:0] ccount_bytes;
  logic [40:0] psz_m1;

  always_comb begin
    psz_m1       = (41'd1 << lg) - 41'd1;
    cnt_sum      = {1'b0, cbytes} + {1'b0, psz_m1};
    ccount       = 41'(cnt_sum >> lg);
    ccount_bytes = 42'(ccount) << lg;
    win_lim      = (meta_win_bytes > LimitBytes) ? LimitBytes : meta_win_bytes;
    win_sum      = {1'b0, win_lim} + {1'b0, psz_m1};
    win_r        = 41'((win_sum >> lg) << lg);
    c_invalid    = (cbytes == '0) || (ccount > 41'(MaxCount)) ||
                   (ccount_bytes > 42'(LimitBytes)) || ({5'd0, req} >= vms);
  end

  // create terms settle in stages while the key walks the chain
  logic [40:0] crt_count;
  logic [40:0] crt_win;
  logic        crt_bad;
  logic [36:0] crt_need;
  always_ff @(posedge clk) begin
    crt_count <= ccount;
    crt_win   <= win_r;
    crt_bad   <= c_invalid;
    crt_need  <= {9'd0, crt_count[27:0]} * {28'd0, mpp};
  end
  assign used_need = 51'(meta_used) + 51'(crt_need);

  // cell chain
  key_t   key;
  match_t chain [MAX_REGIONS+1];
  logic [MAX_REGIONS-1:0] wr_en, clr_en;
  logic [IdxW-1:0] act_idx;

  assign key.by_page = (op == OP_CHECK);
  assign key.id      = rid;
  assign key.page    = 36'(paddr >> lg);
  assign chain[0]    = '0;

  genvar g;
  generate
    for (g = 0; g < MAX_REGIONS; g++) begin : g_cell
      rpt_cell #(.Index(g)) u_cell (
        .clk(clk), .rst(rst), .key(key),
        .match_in(chain[g]), .match_out(chain[g+1]),
        .wr_en(wr_en[g]), .clr_en(clr_en[g]),
        .wr_id(next_id), .wr_base_page(cbase),
        .wr_page_count(crt_count[27:0]), .wr_owner(req),
        .wr_meta_base(48'(meta_win_base + 48'(meta_used)))
      );
    end
  endgenerate

  match_t m;
  assign m = chain[MAX_REGIONS];

  // execute decision
  logic        do_create, do_owned_ok, do_destroy, do_perm_wr;
  status_t     st;
  logic [2:0]  perm_rd;
  logic [IdxW-1:0] hit_idx;
  assign hit_idx = m.idx[IdxW-1:0];

  always_comb begin
    do_create   = 1'b0;
    do_owned_ok = 1'b0;
    do_destroy  = 1'b0;
    do_perm_wr  = 1'b0;
    st          = ST_OK;
    unique case (op)
      OP_CREATE: begin
        if (crt_bad) st = ST_INVALID;
        else if (used_need > 51'(crt_win)) st = ST_EXHAUSTED;
        else if (!m.any_free) st = ST_FULL;
        else do_create = 1'b1;
      end
      OP_GRANT, OP_REVOKE, OP_DESTROY: begin
        if (!m.hit) st = ST_NOTFOUND;
        else if ({5'd0, req} >= vms) st = ST_INVALID;
        else if (m.owner != req) st = ST_DENIED;
        else if (op == OP_DESTROY) begin
          do_destroy = 1'b1; do_owned_ok = 1'b1;
        end else if ({1'b0, tgt} >= vms) st = ST_INVALID;
        else begin
          do_perm_wr = 1'b1; do_owned_ok = 1'b1;
        end
      end
      OP_QUERY, OP_CHECK: st = m.hit ? ST_OK : ST_NOTFOUND;
      default: st = ST_INVALID;
    endcase
  end

  // fsm
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (s_axis_tvalid) state_next = S_SCAN;
      S_SCAN: if (cnt == CntW'(MAX_REGIONS)) state_next = S_EXEC;
      S_EXEC: state_next = S_OUT;
      S_OUT:  if (m_axis_tready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = (state == S_IDLE);
    m_axis_tvalid = (state == S_OUT);
    act_idx = do_create ? m.free_idx[IdxW-1:0] : hit_idx;
    for (int i = 0; i < MAX_REGIONS; i++) begin
      wr_en[i]  = (state == S_EXEC) && do_create && (act_idx == IdxW'(i));
      clr_en[i] = (state == S_EXEC) && do_destroy && (act_idx == IdxW'(i));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= (state == S_SCAN) ? cnt + 1'b1 : '0;
    end
  end

  // capture
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      op     <= s_axis_tdata[2:0];
      req    <= s_axis_tdata[6:3];
      rid    <= s_axis_tdata[38:7];
      tgt    <= s_axis_tdata[46:39];
      perm   <= s_axis_tdata[49:47];
      cbytes <= s_axis_tdata[90:50];
      cbase  <= s_axis_tdata[126:91];
      gall   <= s_axis_tdata[127];
      paddr  <= s_axis_tdata[175:128];
    end
  end

  // permission memory, read one entry during scan end
  always_ff @(posedge clk) begin
    perm_rd <= perm_mem[{m.idx[IdxW-1:0], tgt[3:0]}];
  end

  // permission write, one entry per cycle: create sweeps after execute
  logic [4:0] sweep;
  logic       sweep_on;
  logic [IdxW-1:0] sweep_row;
  logic [3:0] sweep_req;
  logic       sweep_gall;
  logic [8:0] sweep_vms;
  logic [2:0] sweep_p;
  always_comb begin
    sweep_p = 3'd0;
    if ({4'd0, sweep} < sweep_vms) begin
      if (sweep[3:0] == sweep_req) sweep_p = 3'd7;
      if (sweep_gall) sweep_p = sweep_p | 3'd3;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_on <= 1'b0;
      sweep    <= '0;
    end else if (state == S_EXEC && do_create) begin
      sweep_on   <= 1'b1;
      sweep      <= '0;
      sweep_row  <= m.free_idx[IdxW-1:0];
      sweep_req  <= req;
      sweep_gall <= gall;
      sweep_vms  <= vms;
    end else if (sweep_on) begin
      sweep <= sweep + 5'd1;
      if (sweep == 5'(MaxVmids - 1)) sweep_on <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sweep_on) begin
      perm_mem[{sweep_row, sweep[3:0]}] <= sweep_p;
    end else if (state == S_EXEC && do_perm_wr) begin
      perm_mem[{hit_idx, tgt[3:0]}] <= (op == OP_GRANT) ? perm : 3'd0;
    end
  end

  // metadata offset of the page, settled before execute
  logic [36:0] poff;
  logic [36:0] meta_off;
  assign poff = 37'(key.page - m.base_page);

  always_ff @(posedge clk) begin
    meta_off <= {9'd0, poff[27:0]} * {28'd0, mpp};
  end

  // state counters and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      next_id   <= 32'd1;
      meta_used <= '0;
      epoch     <= '0;
    end else if (state == S_EXEC) begin
      if (do_create) begin
        next_id   <= (next_id == 32'hFFFF_FFFF) ? 32'd1 : next_id + 32'd1;
        meta_used <= 41'(used_need);
      end
      if (do_create || do_owned_ok) epoch <= epoch + 32'd1;
    end
  end

  logic [199:0] result_next;
  always_comb begin
    result_next = '0;
    result_next[2:0] = st;
    if (op == OP_CREATE && do_create) result_next[34:3] = next_id;
    if (op == OP_QUERY && m.hit) begin
      result_next[75:35]   = 41'({13'd0, m.page_count} << lg);
      result_next[111:76]  = m.base_page;
      result_next[115:112] = m.owner;
    end
    if (op == OP_CHECK && m.hit) begin
      result_next[34:3] = m.id;
      if ({1'b0, tgt} < vms) begin
        result_next[116] = ((perm_rd & perm) == perm);
        result_next[164:117] = 48'(m.meta_base + 48'(meta_off));
      end
    end
    result_next[196:165] = epoch + 32'(do_create || do_owned_ok);
  end

  always_ff @(posedge clk) begin
    if (state == S_EXEC) begin
      m_axis_tdata <= result_next;
    end
  end

endmodule

### src/rpt_checker.sv
// port-level checks for the region permission table, bound to the top
module rpt_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [199:0] m_axis_tdata
);
  import rpt_pkg::*;

  // no input while a result waits
  a_excl: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready) else $error("input ready with result pending");

  // a result holds while stalled
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed under stall");

  // status codes stay in range
  a_st: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[2:0] <= ST_FULL) else $error("bad status");

  // accepted input leaves ready low next cycle
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready) else $error("ready stayed high");

endmodule

bind region_permission_table rpt_checker u_rpt_checker (
  .clk(clk), .rst(rst),
  .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata)
);

### tb/sv/tb.sv
// testbench for the region permission table: directed table plus random operations
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rpt_pkg::*;

  localparam int NumRegions = 16;
  localparam int NumVms     = 16;
  localparam longint CycleLimit = 2000000;

  logic         clk;
  logic         rst;
  // op, requester_vmid, region_id, target_vmid, perm_bits, create_bytes,
  // create_page_base, all_rw, phys_addr
  logic [175:0] s_axis_tdata;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  // status, result_region_id, region_bytes, region_page_base, region_owner,
  // access_allowed, metadata_addr, permission_epoch
  logic [199:0] m_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic         cfg_we;
  logic [1:0]   cfg_index;
  logic [47:0]  cfg_data;

  region_permission_table u_top (.*);

  typedef struct packed {
    logic [47:0] phys_addr;
    logic        all_rw;
    logic [35:0] create_page_base;
    logic [40:0] create_bytes;
    logic [2:0]  perm_bits;
    logic [7:0]  target_vmid;
    logic [31:0] region_id;
    logic [3:0]  requester_vmid;
    logic [2:0]  op;
  } req_t;

  typedef struct packed {
    logic [2:0]  pad;
    logic [31:0] epoch;
    logic [47:0] meta_addr;
    logic        allowed;
    logic [3:0]  owner;
    logic [35:0] base_page;
    logic [40:0] bytes;
    logic [31:0] region_id;
    logic [2:0]  status;
  } resp_t;

  // model copy of the table
  logic [4:0]  m_vmid_count;
  logic [4:0]  m_page_log2;
  logic [47:0] m_win_base;
  logic [40:0] m_win_bytes;
  logic        t_valid [NumRegions];
  logic [31:0] t_id    [NumRegions];
  logic [35:0] t_base  [NumRegions];
  logic [27:0] t_count [NumRegions];
  logic [3:0]  t_owner [NumRegions];
  logic [47:0] t_meta  [NumRegions];
  logic [2:0]  t_perm  [NumRegions][NumVms];
  logic [31:0] t_next_id;
  logic [40:0] t_meta_used;
  logic [31:0] t_epoch;

  resp_t  pending_resp[$];
  req_t   offer_q[$];
  int     mismatches;
  longint cycles;
  int     send_idle_pct, recv_idle_pct;
  bit     recv_hold;
  bit     in_taken;

  function automatic int vms_eff();
    if (m_vmid_count == 0) return 1;
    if (m_vmid_count > NumVms) return NumVms;
    return m_vmid_count;
  endfunction

  function automatic int log2_eff();
    if (m_page_log2 < 12) return 12;
    if (m_page_log2 > 30) return 30;
    return m_page_log2;
  endfunction

  function automatic longint bytes_per_page();
    return ((vms_eff() + MetaLineBytes - 1) / MetaLineBytes) * MetaLineBytes;
  endfunction

  function automatic int find_by_id(logic [31:0] id);
    for (int i = 0; i < NumRegions; i++)
      if (t_valid[i] && t_id[i] == id) return i;
    return -1;
  endfunction

  // compute the response of one operation and update the table copy
  function automatic resp_t table_apply(req_t r);
    resp_t o;
    int lg, vms, e, slot;
    longint unsigned psz, cnt, need, win, page;
    logic [2:0] p;
    o = '0;
    lg = log2_eff();
    vms = vms_eff();
    psz = 64'd1 << lg;
    case (r.op)
      OP_CREATE: begin
        cnt = (64'(r.create_bytes) + psz - 1) >> lg;
        if (r.create_bytes == 0 || cnt > 64'hFFF_FFFF || (cnt << lg) > 64'h100_0000_0000 ||
            r.requester_vmid >= vms) begin
          o.status = ST_INVALID;
        end else begin
          need = bytes_per_page() * cnt;
          win = 64'(m_win_bytes);
          if (win > 64'h100_0000_0000) win = 64'h100_0000_0000;
          win = ((win + psz - 1) >> lg) << lg;
          slot = -1;
          for (int i = NumRegions - 1; i >= 0; i--) if (!t_valid[i]) slot = i;
          if (64'(t_meta_used) + need > win) o.status = ST_EXHAUSTED;
          else if (slot < 0) o.status = ST_FULL;
          else begin
            t_id[slot] = t_next_id;
            t_next_id = t_next_id + 32'd1;
            if (t_next_id == 0) t_next_id = 32'd1;
            t_base[slot] = r.create_page_base;
            t_count[slot] = 28'(cnt);
            t_owner[slot] = r.requester_vmid;
            t_meta[slot] = m_win_base + 48'(t_meta_used);
            t_meta_used = 41'(64'(t_meta_used) + need);
            for (int v = 0; v < NumVms; v++) begin
              p = 3'b000;
              if (v < vms) begin
                if (v == r.requester_vmid) p = 3'b111;
                if (r.all_rw) p |= 3'b011;
              end
              t_perm[slot][v] = p;
            end
            t_valid[slot] = 1;
            t_epoch++;
            o.status = ST_OK;
            o.region_id = t_id[slot];
          end
        end
      end
      OP_GRANT, OP_REVOKE, OP_DESTROY: begin
        e = find_by_id(r.region_id);
        if (e < 0) o.status = ST_NOTFOUND;
        else if (r.requester_vmid >= vms) o.status = ST_INVALID;
        else if (t_owner[e] != r.requester_vmid) o.status = ST_DENIED;
        else if (r.op != OP_DESTROY && r.target_vmid >= vms) o.status = ST_INVALID;
        else begin
          if (r.op == OP_DESTROY) t_valid[e] = 0;
          else t_perm[e][r.target_vmid] = (r.op == OP_GRANT) ? r.perm_bits : 3'b000;
          t_epoch++;
          o.status = ST_OK;
        end
      end
      OP_QUERY: begin
        e = find_by_id(r.region_id);
        if (e < 0) o.status = ST_NOTFOUND;
        else begin
          o.status = ST_OK;
          o.bytes = 41'(64'(t_count[e]) << lg);
          o.base_page = t_base[e];
          o.owner = t_owner[e];
        end
      end
      OP_CHECK: begin
        page = 64'(r.phys_addr) >> lg;
        e = -1;
        for (int i = NumRegions - 1; i >= 0; i--)
          if (t_valid[i] && page >= t_base[i] && page - t_base[i] < t_count[i]) e = i;
        if (e < 0) o.status = ST_NOTFOUND;
        else begin
          o.status = ST_OK;
          o.region_id = t_id[e];
          if (r.target_vmid < vms) begin
            p = t_perm[e][r.target_vmid];
            o.allowed = ((p & r.perm_bits) == r.perm_bits);
            o.meta_addr = 48'(t_meta[e] + (page - t_base[e]) * bytes_per_page()
                              + (r.target_vmid / MetaLineBytes) * MetaLineBytes);
          end
        end
      end
      default: o.status = ST_INVALID;
    endcase
    o.epoch = t_epoch;
    return o;
  endfunction

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // accept / predict at rising edge
  always @(posedge clk) begin
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      pending_resp.push_back(table_apply(req_t'(s_axis_tdata)));
      void'(offer_q.pop_front());
      in_taken = 1;
    end
  end

  // check responses
  always @(posedge clk) begin
    resp_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = resp_t'(m_axis_tdata);
      if (pending_resp.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected response %h", m_axis_tdata);
      end else begin
        want = pending_resp.pop_front();
        if (got.status != want.status || got.region_id != want.region_id ||
            got.bytes != want.bytes || got.base_page != want.base_page ||
            got.owner != want.owner || got.allowed != want.allowed ||
            got.meta_addr != want.meta_addr || got.epoch != want.epoch) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %h got %h", want, got);
        end
      end
    end
  end

  // input driver: valid stays up until accepted
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 0;
    end else if (s_axis_tvalid && !in_taken) begin
      // hold current transaction
    end else if (offer_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
      s_axis_tvalid <= 1;
      s_axis_tdata <= 176'(offer_q[0]);
    end else begin
      s_axis_tvalid <= 0;
    end
    in_taken = 0;
  end

  // receiver ready
  always @(negedge clk) begin
    if (rst) m_axis_tready <= 0;
    else m_axis_tready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
  end

  // queue one transaction; wait only while more than eight are still queued
  task automatic issue(req_t r);
    offer_q.push_back(r);
    while (offer_q.size() > 8) @(posedge clk);
  endtask

  task automatic drain();
    while (offer_q.size() > 0 || pending_resp.size() > 0) @(posedge clk);
    repeat (NumRegions + 8) @(posedge clk);
  endtask

  task automatic write_reg(cfg_index_t idx, logic [47:0] val);
    @(negedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 0;
    case (idx)
      CFG_VMID_COUNT: m_vmid_count = val[4:0];
      CFG_PAGE_LOG2:  m_page_log2 = val[4:0];
      CFG_META_BASE:  m_win_base = val;
      default:        m_win_bytes = val[40:0];
    endcase
  endtask

  // random operation, biased toward existing regions and owners
  function automatic req_t rand_req();
    req_t r;
    int k;
    r = '0;
    r.op = ($urandom_range(99) < 3) ? 3'($urandom_range(7)) : 3'($urandom_range(5));
    if ($urandom_range(99) < 25) r.op = OP_CREATE;
    r.requester_vmid = $urandom_range(99) < 80 ? 4'($urandom_range(vms_eff() - 1)) :
                       4'($urandom);
    r.region_id = $urandom_range(99) < 80 ? $urandom_range(t_next_id + 1) : $urandom;
    k = $urandom_range(NumRegions - 1);
    if (t_valid[k] && $urandom_range(99) < 70) begin
      r.region_id = t_id[k];
      if ($urandom_range(99) < 70) r.requester_vmid = t_owner[k];
    end
    r.target_vmid = $urandom_range(99) < 85 ? 8'($urandom_range(vms_eff() - 1)) :
                    8'($urandom);
    r.perm_bits = 3'($urandom);
    r.all_rw = 1'($urandom);
    r.create_bytes = $urandom_range(99) < 90 ? 41'($urandom_range(1, 40000)) :
                     41'({$urandom, $urandom});
    r.create_page_base = $urandom_range(99) < 80 ? 36'($urandom_range(200)) :
                         36'({$urandom, $urandom});
    if (t_valid[k] && $urandom_range(99) < 80)
      r.phys_addr = 48'((64'(t_base[k]) + $urandom_range(t_count[k])) << log2_eff())
                    | 48'($urandom_range((1 << log2_eff()) - 1));
    else
      r.phys_addr = 48'({$urandom, $urandom});
    return r;
  endfunction

  typedef struct {
    req_t  r;
    bit    known;
    logic [2:0] status;
  } row_t;

  initial begin
    row_t rows[$];
    req_t r;
    resp_t dummy;
    int phase;

    rst = 1;
    cfg_we = 0;
    cfg_index = 0;
    cfg_data = 0;
    s_axis_tvalid = 0;
    s_axis_tdata = 0;
    m_axis_tready = 0;
    mismatches = 0;
    cycles = 0;
    recv_hold = 0;
    in_taken = 0;
    send_idle_pct = 14;
    recv_idle_pct = 88;
    m_vmid_count = 16; m_page_log2 = 12; m_win_base = 0; m_win_bytes = 0;
    foreach (t_valid[i]) t_valid[i] = 0;
    t_next_id = 1; t_meta_used = 0; t_epoch = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // create fails with an empty window, other rows give invalid and not found, then open it
    r = '0; r.op = OP_CREATE; r.create_bytes = 100;
    rows.push_back('{r, 1, ST_EXHAUSTED});
    r.create_bytes = 0;
    rows.push_back('{r, 1, ST_INVALID});
    r = '0; r.op = 3'd6;
    rows.push_back('{r, 1, ST_INVALID});
    r.op = 3'd7;
    rows.push_back('{r, 1, ST_INVALID});
    r = '0; r.op = OP_QUERY; r.region_id = 0;
    rows.push_back('{r, 1, ST_NOTFOUND});
    r = '0; r.op = OP_CHECK; r.phys_addr = '1;
    rows.push_back('{r, 1, ST_NOTFOUND});
    foreach (rows[i]) begin
      dummy = table_apply(rows[i].r);
      if (rows[i].known && dummy.status != rows[i].status) begin
        mismatches++;
        if (mismatches <= 10)
          $display("directed row %0d: expected status %0d, got %0d", i, rows[i].status,
                   dummy.status);
      end
    end
    // rewind the copy: the rows are replayed through the block
    t_epoch = 0;
    foreach (rows[i]) offer_q.push_back(rows[i].r);
    drain();

    write_reg(CFG_META_BASE, 48'hFFFF_FFFF_F000);
    write_reg(CFG_META_BYTES, 48'h100_0000_0000);
    rows.delete();
    r = '0; r.op = OP_CREATE; r.requester_vmid = 15; r.create_bytes = 1;
    r.create_page_base = '1; r.all_rw = 1;
    rows.push_back('{r, 0, 0});
    r.create_bytes = 41'h100_0000_0000; r.requester_vmid = 0; r.create_page_base = 0;
    r.all_rw = 0;
    rows.push_back('{r, 0, 0});
    r.create_bytes = 41'h100_0000_0001;
    rows.push_back('{r, 0, 0});
    r = '0; r.op = OP_QUERY; r.region_id = 1;
    rows.push_back('{r, 0, 0});
    r = '0; r.op = OP_GRANT; r.region_id = 1; r.requester_vmid = 15;
    r.target_vmid = 3; r.perm_bits = 3'b100;
    rows.push_back('{r, 0, 0});
    r.requester_vmid = 2;
    rows.push_back('{r, 0, 0});
    r.requester_vmid = 15; r.target_vmid = 8'hFF;
    rows.push_back('{r, 0, 0});
    r = '0; r.op = OP_CHECK; r.phys_addr = 48'hFFFF_FFFF_FFFF; r.target_vmid = 3;
    r.perm_bits = 3'b100;
    rows.push_back('{r, 0, 0});
    r.target_vmid = 8'hFF;
    rows.push_back('{r, 0, 0});
    r = '0; r.op = OP_REVOKE; r.region_id = 1; r.requester_vmid = 15; r.target_vmid = 3;
    rows.push_back('{r, 0, 0});
    r = '0; r.op = OP_DESTROY; r.region_id = 2; r.requester_vmid = 0;
    rows.push_back('{r, 0, 0});
    r.region_id = 32'hFFFF_FFFF;
    rows.push_back('{r, 0, 0});
    foreach (rows[i]) issue(rows[i].r);
    drain();

    // table full: many small creates
    for (int i = 0; i < 18; i++) begin
      r = '0; r.op = OP_CREATE; r.create_bytes = 4096; r.create_page_base = 36'(i * 4);
      r.requester_vmid = 4'(i % 16);
      issue(r);
    end
    drain();

    // random phases across settings
    for (phase = 0; phase < 6; phase++) begin
      if (phase == 2) begin send_idle_pct = 88; recv_idle_pct = 14; end
      if (phase == 4) begin send_idle_pct = 0; recv_idle_pct = 0; end
      case (phase)
        0: begin
          write_reg(CFG_VMID_COUNT, 48'd0);
          write_reg(CFG_PAGE_LOG2, 48'd30);
        end
        1: begin
          write_reg(CFG_VMID_COUNT, 48'd31);
          write_reg(CFG_PAGE_LOG2, 48'd0);
          write_reg(CFG_META_BYTES, 48'h1F_FFFF_FFFF);
        end
        2: begin
          write_reg(CFG_VMID_COUNT, 48'd5);
          write_reg(CFG_PAGE_LOG2, 48'd12);
          write_reg(CFG_META_BASE, 48'h1000);
          write_reg(CFG_META_BYTES, 48'h40000);
        end
        3: begin
          write_reg(CFG_VMID_COUNT, 48'd16);
          write_reg(CFG_PAGE_LOG2, 48'd31);
          write_reg(CFG_META_BYTES, 48'h1FF_FFFF_FFFF);
        end
        4: begin
          write_reg(CFG_VMID_COUNT, 48'd1);
          write_reg(CFG_PAGE_LOG2, 48'd13);
        end
        default: begin
          write_reg(CFG_VMID_COUNT, 48'd12);
          write_reg(CFG_PAGE_LOG2, 48'd20);
          write_reg(CFG_META_BASE, 48'($urandom));
        end
      endcase
      for (int i = 0; i < 310; i++) begin
        // long receiver hold while items keep coming
        if (phase == 4 && i == 10) begin
          fork
            begin
              recv_hold = 1;
              repeat (300) @(posedge clk);
              recv_hold = 0;
            end
          join_none
        end
        issue(rand_req());
      end
      drain();
    end

    if (mismatches == 0 && pending_resp.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
